/* rtl/core/pci_pkg.sv */
// Types, codes and the CRC-8 function shared by the pedal command interceptor.
// Has no dependencies; every other file in rtl/core imports it.
package pci_pkg;

  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [10:0] CMD_ID_RESET    = 11'h200;
  localparam logic [10:0] STATUS_ID_RESET = 11'h201;
  localparam logic [3:0]  TIMEOUT_RESET   = 4'd10;

  localparam logic [1:0] MODE_COMMAND   = 2'd0;
  localparam logic [1:0] MODE_TICK      = 2'd1;
  localparam logic [1:0] MODE_SAMPLE    = 2'd2;
  localparam logic [1:0] MODE_BUS_ERROR = 2'd3;

  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_CHECKSUM = 3'd1;
  localparam logic [2:0] FLT_TX_BUSY  = 3'd2;
  localparam logic [2:0] FLT_BUS      = 3'd3;
  localparam logic [2:0] FLT_POWER_UP = 3'd4;
  localparam logic [2:0] FLT_STALE    = 3'd5;
  localparam logic [2:0] FLT_BAD_CMD  = 3'd6;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DRIVE  = 1'b1;

  localparam logic [1:0] REG_COMMAND_ID = 2'd0;
  localparam logic [1:0] REG_STATUS_ID  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT    = 2'd2;

  typedef struct packed {
    logic [10:0] command_frame_id;
    logic [10:0] status_frame_id;
    logic [3:0]  timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] frame_id;
    logic [15:0] target_a;
    logic [15:0] target_b;
    logic [7:0]  control_byte;
    logic [7:0]  check_byte;
    logic [11:0] sample_a;
    logic [11:0] sample_b;
    logic        mailbox_free;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [10:0] out_frame_id;
    logic [15:0] report_a;
    logic [15:0] report_b;
    logic [7:0]  report_control;
    logic [7:0]  report_check;
    logic [11:0] drive_a;
    logic [11:0] drive_b;
    logic [2:0]  fault_now;
  } result_t;

  // The message holds byte 4 in its top bits down to byte 0, so it is fed in MSB first.
  function automatic logic [7:0] crc8_five(input logic [39:0] msg);
    logic [7:0] crc;
    crc = CRC_INIT;
    for (int i = 39; i >= 0; i--) begin
      if (crc[7] ^ msg[i]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

/* rtl/core/pci_cfg_regs.sv */
// Configuration registers of the pedal command interceptor behind an APB-style port.
// Depends on pci_pkg for the register indexes, reset values and cfg_t.
module pci_cfg_regs import pci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.command_frame_id <= CMD_ID_RESET;
      cfg.status_frame_id  <= STATUS_ID_RESET;
      cfg.timeout_limit    <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_COMMAND_ID: cfg.command_frame_id <= pwdata[10:0];
        REG_STATUS_ID:  cfg.status_frame_id  <= pwdata[10:0];
        REG_TIMEOUT:    cfg.timeout_limit    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_COMMAND_ID: prdata = {21'd0, cfg.command_frame_id};
      REG_STATUS_ID:  prdata = {21'd0, cfg.status_frame_id};
      REG_TIMEOUT:    prdata = {28'd0, cfg.timeout_limit};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/pci_in_stage.sv */
// Input register of the pedal command interceptor: holds one accepted word until the engine takes it.
// Depends on pci_pkg for item_t.
module pci_in_stage import pci_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t item_in,
  input  logic  take,
  output logic  held,
  output item_t item
);

  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

endmodule

/* rtl/core/pci_engine.sv */
// Single-pass engine: checks commands, keeps fault and counter state and forms each result word.
// Depends on pci_pkg for codes, the CRC-8 function and the cfg_t, item_t and result_t types.
module pci_engine import pci_pkg::*; #(
  parameter int DAC_BITS = 12
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    held,
  input  item_t   item,
  input  logic    out_free,
  output logic    take,
  output logic    res_load,
  output result_t res
);

  localparam logic [15:0] FULL_SCALE =
    (DAC_BITS >= 12) ? 16'd4095 : 16'((1 << DAC_BITS) - 1);

  logic [15:0] gas_a, gas_a_next;
  logic [15:0] gas_b, gas_b_next;
  logic [2:0]  fault_code, fault_code_next;
  logic [3:0]  idle_ticks, idle_ticks_next;
  logic [3:0]  last_rx_count, last_rx_count_next;
  logic [3:0]  tx_count, tx_count_next;
  logic [11:0] held_sample_a, held_sample_a_next;
  logic [11:0] held_sample_b, held_sample_b_next;

  logic        makes_result;
  logic [3:0]  rx_count;
  logic [7:0]  cmd_crc;
  logic [7:0]  status_control;
  logic [7:0]  status_crc;
  logic [15:0] pick_a, pick_b;

  assign makes_result = (item.mode == MODE_TICK && item.mailbox_free) ||
                        (item.mode == MODE_SAMPLE);
  assign take     = held && (!makes_result || out_free);
  assign res_load = take && makes_result;

  assign rx_count = item.control_byte[3:0];
  assign cmd_crc  = crc8_five({item.control_byte, item.target_b[7:0], item.target_b[15:8],
                               item.target_a[7:0], item.target_a[15:8]});

  assign status_control = {1'b0, fault_code, tx_count};
  assign status_crc = crc8_five({status_control, held_sample_b[7:0], 4'd0, held_sample_b[11:8],
                                 held_sample_a[7:0], 4'd0, held_sample_a[11:8]});

  always_comb begin
    pick_a = {4'd0, item.sample_a};
    pick_b = {4'd0, item.sample_b};
    if (fault_code == FLT_NONE && gas_a > pick_a) begin
      pick_a = gas_a;
    end
    if (fault_code == FLT_NONE && gas_b > pick_b) begin
      pick_b = gas_b;
    end
    if (pick_a > FULL_SCALE) begin
      pick_a = FULL_SCALE;
    end
    if (pick_b > FULL_SCALE) begin
      pick_b = FULL_SCALE;
    end
  end

  always_comb begin
    gas_a_next         = gas_a;
    gas_b_next         = gas_b;
    fault_code_next    = fault_code;
    idle_ticks_next    = idle_ticks;
    last_rx_count_next = last_rx_count;
    tx_count_next      = tx_count;
    held_sample_a_next = held_sample_a;
    held_sample_b_next = held_sample_b;
    res                = '0;
    res.fault_now      = fault_code;

    unique case (item.mode)
      MODE_COMMAND: begin
        if (item.frame_id == cfg.command_frame_id) begin
          if (cmd_crc == item.check_byte) begin
            if (4'(last_rx_count + 4'd1) == rx_count) begin
              if (item.control_byte[7]) begin
                gas_a_next = item.target_a;
                gas_b_next = item.target_b;
              end else begin
                fault_code_next = (item.target_a == 16'd0 && item.target_b == 16'd0) ?
                                  FLT_NONE : FLT_BAD_CMD;
                gas_a_next = 16'd0;
                gas_b_next = 16'd0;
              end
              idle_ticks_next = 4'd0;
            end
            last_rx_count_next = rx_count;
          end else begin
            fault_code_next = FLT_CHECKSUM;
          end
        end
      end
      MODE_TICK: begin
        if (item.mailbox_free) begin
          res.result_kind    = KIND_STATUS;
          res.out_frame_id   = cfg.status_frame_id;
          res.report_a       = {4'd0, held_sample_a};
          res.report_b       = {4'd0, held_sample_b};
          res.report_control = status_control;
          res.report_check   = status_crc;
          tx_count_next      = 4'(tx_count + 4'd1);
        end else begin
          fault_code_next = FLT_TX_BUSY;
        end
        if (idle_ticks == cfg.timeout_limit) begin
          fault_code_next = FLT_STALE;
        end else begin
          idle_ticks_next = 4'(idle_ticks + 4'd1);
        end
      end
      MODE_SAMPLE: begin
        held_sample_a_next = item.sample_a;
        held_sample_b_next = item.sample_b;
        res.result_kind    = KIND_DRIVE;
        res.drive_a        = pick_a[11:0];
        res.drive_b        = pick_b[11:0];
      end
      MODE_BUS_ERROR: begin
        fault_code_next = FLT_BUS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gas_a         <= 16'd0;
      gas_b         <= 16'd0;
      fault_code    <= FLT_POWER_UP;
      idle_ticks    <= 4'd0;
      last_rx_count <= 4'd0;
      tx_count      <= 4'd0;
      held_sample_a <= 12'd0;
      held_sample_b <= 12'd0;
    end else if (take) begin
      gas_a         <= gas_a_next;
      gas_b         <= gas_b_next;
      fault_code    <= fault_code_next;
      idle_ticks    <= idle_ticks_next;
      last_rx_count <= last_rx_count_next;
      tx_count      <= tx_count_next;
      held_sample_a <= held_sample_a_next;
      held_sample_b <= held_sample_b_next;
    end
  end

  // The send counter moves exactly when a status word is formed.
  a_tx_count_step: assert property (@(posedge clk) disable iff (rst)
    (res_load && item.mode == MODE_TICK) |=> tx_count == 4'($past(tx_count) + 4'd1))
    else $error("send counter did not step with a status word");

  a_tx_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(res_load && item.mode == MODE_TICK) |=> $stable(tx_count))
    else $error("send counter moved without a status word");

  a_bus_fault: assert property (@(posedge clk) disable iff (rst)
    (take && item.mode == MODE_BUS_ERROR) |=> fault_code == FLT_BUS)
    else $error("bus error did not latch its fault");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result formed while the result register was full");

endmodule

/* rtl/core/pci_out_stage.sv */
// Result register of the pedal command interceptor, which holds one word until it is taken.
// Depends on pci_pkg for result_t.
module pci_out_stage import pci_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_load,
  input  result_t res,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    out_free,
  output result_t res_q
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

endmodule

/* rtl/core/pedal_command_interceptor_core.sv */
// Pedal command interceptor top level. A word is registered on acceptance, and its result word
// is registered when the engine takes it; one word per cycle is sustained while results are taken.
// A word that yields a result waits in the input register while the result register is full.
// Synchronous reset returns the registers to their defaults, the fault to startup and the
// counters, targets and held samples to zero. Depends on pci_pkg and the pci_* modules.
module pedal_command_interceptor_core import pci_pkg::*; #(
  parameter int DAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [10:0] frame_id,
  input  logic [15:0] target_a,
  input  logic [15:0] target_b,
  input  logic [7:0]  control_byte,
  input  logic [7:0]  check_byte,
  input  logic [11:0] sample_a,
  input  logic [11:0] sample_b,
  input  logic        mailbox_free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [10:0] out_frame_id,
  output logic [15:0] report_a,
  output logic [15:0] report_b,
  output logic [7:0]  report_control,
  output logic [7:0]  report_check,
  output logic [11:0] drive_a,
  output logic [11:0] drive_b,
  output logic [2:0]  fault_now
);

  cfg_t    cfg;
  item_t   item_in;
  item_t   item;
  logic    held;
  logic    take;
  logic    res_load;
  logic    out_free;
  result_t res;
  result_t res_q;

  assign item_in.mode         = mode;
  assign item_in.frame_id     = frame_id;
  assign item_in.target_a     = target_a;
  assign item_in.target_b     = target_b;
  assign item_in.control_byte = control_byte;
  assign item_in.check_byte   = check_byte;
  assign item_in.sample_a     = sample_a;
  assign item_in.sample_b     = sample_b;
  assign item_in.mailbox_free = mailbox_free;

  pci_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pci_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item_in  (item_in),
    .take     (take),
    .held     (held),
    .item     (item)
  );

  pci_engine #(
    .DAC_BITS (DAC_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .held     (held),
    .item     (item),
    .out_free (out_free),
    .take     (take),
    .res_load (res_load),
    .res      (res)
  );

  pci_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_free  (out_free),
    .res_q     (res_q)
  );

  assign result_kind    = res_q.result_kind;
  assign out_frame_id   = res_q.out_frame_id;
  assign report_a       = res_q.report_a;
  assign report_b       = res_q.report_b;
  assign report_control = res_q.report_control;
  assign report_check   = res_q.report_check;
  assign drive_a        = res_q.drive_a;
  assign drive_b        = res_q.drive_b;
  assign fault_now      = res_q.fault_now;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for pedal_command_interceptor_core: a directed table, then random words.
// Depends on pci_pkg and the core RTL; it predicts every result word and checks it in order.
module testbench;
  import pci_pkg::*;

  localparam int DAC_BITS = 12;
  localparam int FULL_SCALE = ((1 << DAC_BITS) - 1 > 4095) ? 4095 : (1 << DAC_BITS) - 1;
  localparam int DRAIN_CYCLES = 4;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 190;

  typedef struct {
    item_t   word;
    bit      typed;
    result_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = '0;
  logic [10:0] frame_id = '0;
  logic [15:0] target_a = '0;
  logic [15:0] target_b = '0;
  logic [7:0]  control_byte = '0;
  logic [7:0]  check_byte = '0;
  logic [11:0] sample_a = '0;
  logic [11:0] sample_b = '0;
  logic        mailbox_free = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [10:0] out_frame_id;
  logic [15:0] report_a;
  logic [15:0] report_b;
  logic [7:0]  report_control;
  logic [7:0]  report_check;
  logic [11:0] drive_a;
  logic [11:0] drive_b;
  logic [2:0]  fault_now;

  logic [10:0] cfg_cmd_id = CMD_ID_RESET;
  logic [10:0] cfg_status_id = STATUS_ID_RESET;
  logic [3:0]  cfg_timeout = TIMEOUT_RESET;
  logic [15:0] cmd_gas_a = '0;
  logic [15:0] cmd_gas_b = '0;
  logic [2:0]  latched_fault = FLT_POWER_UP;
  logic [3:0]  ticks_since_cmd = '0;
  logic [3:0]  rx_counter = '0;
  logic [3:0]  tx_counter = '0;
  logic [11:0] pedal_a = '0;
  logic [11:0] pedal_b = '0;

  result_t expected_results[$];
  row_t    directed_rows[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      calm = 1'b0;

  pedal_command_interceptor_core #(.DAC_BITS(DAC_BITS)) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .frame_id(frame_id), .target_a(target_a), .target_b(target_b),
    .control_byte(control_byte), .check_byte(check_byte),
    .sample_a(sample_a), .sample_b(sample_b), .mailbox_free(mailbox_free),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .out_frame_id(out_frame_id),
    .report_a(report_a), .report_b(report_b),
    .report_control(report_control), .report_check(report_check),
    .drive_a(drive_a), .drive_b(drive_b), .fault_now(fault_now)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] frame_crc(input logic [15:0] first_pair,
                                           input logic [15:0] second_pair,
                                           input logic [7:0] ctl);
    logic [39:0] msg;
    logic [7:0]  crc;
    int          i;
    int          j;
    msg = {ctl, second_pair[7:0], second_pair[15:8], first_pair[7:0], first_pair[15:8]};
    crc = CRC_INIT;
    for (i = 0; i < 5; i++) begin
      crc = crc ^ msg[39:32];
      for (j = 0; j < 8; j++) begin
        crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
      end
      msg = msg << 8;
    end
    return crc;
  endfunction

  function automatic logic [11:0] dac_level(input logic [15:0] gas, input logic [11:0] smp);
    int v;
    v = int'(smp);
    if (latched_fault == FLT_NONE && int'(gas) > v) begin
      v = int'(gas);
    end
    if (v > FULL_SCALE) begin
      v = FULL_SCALE;
    end
    return 12'(v);
  endfunction

  function automatic bit predict_word(input item_t w, output result_t r);
    bit emits;
    emits = 1'b0;
    r = '0;
    case (w.mode)
      MODE_COMMAND: begin
        if (w.frame_id == cfg_cmd_id) begin
          if (frame_crc(w.target_a, w.target_b, w.control_byte) == w.check_byte) begin
            if (rx_counter + 4'd1 == w.control_byte[3:0]) begin
              if (w.control_byte[7]) begin
                cmd_gas_a = w.target_a;
                cmd_gas_b = w.target_b;
              end else begin
                latched_fault = (w.target_a == '0 && w.target_b == '0) ? FLT_NONE
                                                                       : FLT_BAD_CMD;
                cmd_gas_a = '0;
                cmd_gas_b = '0;
              end
              ticks_since_cmd = '0;
            end
            rx_counter = w.control_byte[3:0];
          end else begin
            latched_fault = FLT_CHECKSUM;
          end
        end
      end
      MODE_TICK: begin
        if (w.mailbox_free) begin
          r.result_kind    = KIND_STATUS;
          r.out_frame_id   = cfg_status_id;
          r.report_a       = {4'd0, pedal_a};
          r.report_b       = {4'd0, pedal_b};
          r.report_control = {1'b0, latched_fault, tx_counter};
          r.report_check   = frame_crc(r.report_a, r.report_b, r.report_control);
          r.fault_now      = latched_fault;
          tx_counter       = tx_counter + 4'd1;
          emits            = 1'b1;
        end else begin
          latched_fault = FLT_TX_BUSY;
        end
        if (ticks_since_cmd == cfg_timeout) begin
          latched_fault = FLT_STALE;
        end else begin
          ticks_since_cmd = ticks_since_cmd + 4'd1;
        end
      end
      MODE_SAMPLE: begin
        pedal_a       = w.sample_a;
        pedal_b       = w.sample_b;
        r.result_kind = KIND_DRIVE;
        r.drive_a     = dac_level(cmd_gas_a, w.sample_a);
        r.drive_b     = dac_level(cmd_gas_b, w.sample_b);
        r.fault_now   = latched_fault;
        emits         = 1'b1;
      end
      default: begin
        latched_fault = FLT_BUS;
      end
    endcase
    return emits;
  endfunction

  function automatic item_t word_of(input logic [1:0] m, input logic [10:0] fid,
                                    input logic [15:0] ta, input logic [15:0] tb,
                                    input logic [7:0] ctl, input logic [7:0] chk,
                                    input logic [11:0] sa, input logic [11:0] sb,
                                    input logic mf);
    item_t w;
    w.mode         = m;
    w.frame_id     = fid;
    w.target_a     = ta;
    w.target_b     = tb;
    w.control_byte = ctl;
    w.check_byte   = chk;
    w.sample_a     = sa;
    w.sample_b     = sb;
    w.mailbox_free = mf;
    return w;
  endfunction

  function automatic item_t sealed(input item_t w);
    w.check_byte = frame_crc(w.target_a, w.target_b, w.control_byte);
    return w;
  endfunction

  function automatic result_t drive_word(input logic [11:0] da, input logic [11:0] db,
                                         input logic [2:0] f);
    result_t r;
    r = '0;
    r.result_kind = KIND_DRIVE;
    r.drive_a     = da;
    r.drive_b     = db;
    r.fault_now   = f;
    return r;
  endfunction

  function automatic item_t random_word();
    item_t      w;
    logic [3:0] cnt;
    int         pick;
    w = word_of(2'($urandom), 11'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 12'($urandom), 12'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      w.mode = MODE_COMMAND;
      if ($urandom_range(0, 9) != 0) begin
        w.frame_id = cfg_cmd_id;
      end
      cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom) : rx_counter + 4'd1;
      w.control_byte = {($urandom_range(0, 4) != 0), 3'($urandom), cnt};
      if ($urandom_range(0, 1) == 1) begin
        w.target_a = {4'd0, w.target_a[11:0]};
        w.target_b = {4'd0, w.target_b[11:0]};
      end
      if (!w.control_byte[7] && $urandom_range(0, 9) < 7) begin
        w.target_a = '0;
        w.target_b = '0;
      end
      if ($urandom_range(0, 9) != 0) begin
        w = sealed(w);
      end
    end else if (pick < 68) begin
      w.mode = MODE_TICK;
      w.mailbox_free = ($urandom_range(0, 9) != 0);
    end else if (pick < 96) begin
      w.mode = MODE_SAMPLE;
    end else begin
      w.mode = MODE_BUS_ERROR;
    end
    return w;
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf("kind %0d id %h report %h/%h ctl %h crc %h drive %h/%h fault %0d",
                     r.result_kind, r.out_frame_id, r.report_a, r.report_b,
                     r.report_control, r.report_check, r.drive_a, r.drive_b, r.fault_now);
  endfunction

  task automatic add_row(input item_t w, input bit typed, input result_t want);
    row_t r;
    r.word  = w;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  task automatic send_word(input item_t w, input bit typed, input result_t want);
    int      gap;
    result_t r;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= w.mode;
    frame_id     <= w.frame_id;
    target_a     <= w.target_a;
    target_b     <= w.target_b;
    control_byte <= w.control_byte;
    check_byte   <= w.check_byte;
    sample_a     <= w.sample_a;
    sample_b     <= w.sample_b;
    mailbox_free <= w.mailbox_free;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_word(w, r)) begin
      expected_results.push_back(typed ? want : r);
    end
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr[3:2])
      REG_COMMAND_ID: cfg_cmd_id = data[10:0];
      REG_STATUS_ID:  cfg_status_id = data[10:0];
      REG_TIMEOUT:    cfg_timeout = data[3:0];
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result word: %s", describe(got));
      end
    end else begin
      want = expected_results.pop_front();
      if (got.result_kind !== want.result_kind || got.out_frame_id !== want.out_frame_id ||
          got.report_a !== want.report_a || got.report_b !== want.report_b ||
          got.report_control !== want.report_control ||
          got.report_check !== want.report_check || got.drive_a !== want.drive_a ||
          got.drive_b !== want.drive_b || got.fault_now !== want.fault_now) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    result_t got;
    int      stall;
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.result_kind    = result_kind;
      got.out_frame_id   = out_frame_id;
      got.report_a       = report_a;
      got.report_b       = report_b;
      got.report_control = report_control;
      got.report_check   = report_check;
      got.drive_a        = drive_a;
      got.drive_b        = drive_b;
      got.fault_now      = fault_now;
      check_result(got);
    end
  end

  initial begin
    result_t     none;
    logic [10:0] new_cmd_id;
    logic [10:0] new_status_id;
    logic [3:0]  new_timeout;
    int          p;
    int          k;
    none = '0;

    add_row(word_of(MODE_SAMPLE, 0, 0, 0, 0, 0, 12'd0, 12'd0, 0), 1,
            drive_word(12'd0, 12'd0, FLT_POWER_UP));
    add_row(word_of(MODE_SAMPLE, 0, 0, 0, 0, 0, 12'hFFF, 12'hFFF, 0), 1,
            drive_word(12'hFFF, 12'hFFF, FLT_POWER_UP));
    add_row(word_of(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1), 0, none);
    add_row(word_of(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(sealed(word_of(MODE_COMMAND, 11'd511, 0, 0, 8'h01, 0, 0, 0, 0)), 0, none);
    add_row(sealed(word_of(MODE_COMMAND, 11'd512, 0, 0, 8'h01, 0, 0, 0, 0)), 0, none);
    add_row(word_of(MODE_SAMPLE, 0, 0, 0, 0, 0, 12'd100, 12'd200, 0), 1,
            drive_word(12'd100, 12'd200, FLT_NONE));
    add_row(sealed(word_of(MODE_COMMAND, 11'd512, 16'hFFFF, 16'h0800, 8'h82, 0, 0, 0, 0)),
            0, none);
    add_row(word_of(MODE_SAMPLE, 0, 0, 0, 0, 0, 12'd0, 12'hFFF, 0), 1,
            drive_word(12'hFFF, 12'hFFF, FLT_NONE));
    add_row(word_of(MODE_SAMPLE, 0, 0, 0, 0, 0, 12'h7FF, 12'd0, 0), 1,
            drive_word(12'hFFF, 12'h800, FLT_NONE));
    add_row(word_of(MODE_COMMAND, 11'd512, 16'h1234, 16'h5678, 8'h83,
                    frame_crc(16'h1234, 16'h5678, 8'h83) ^ 8'h5A, 0, 0, 0), 0, none);
    add_row(word_of(MODE_SAMPLE, 0, 0, 0, 0, 0, 12'd5, 12'd6, 0), 1,
            drive_word(12'd5, 12'd6, FLT_CHECKSUM));
    add_row(sealed(word_of(MODE_COMMAND, 11'd512, 0, 0, 8'h05, 0, 0, 0, 0)), 0, none);
    add_row(sealed(word_of(MODE_COMMAND, 11'd512, 16'h0010, 0, 8'h06, 0, 0, 0, 0)), 0, none);
    add_row(word_of(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1), 0, none);
    add_row(word_of(MODE_BUS_ERROR, 11'h7FF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                    12'hFFF, 12'hFFF, 1), 0, none);
    add_row(word_of(MODE_SAMPLE, 0, 0, 0, 0, 0, 12'hFFF, 12'd0, 0), 1,
            drive_word(12'hFFF, 12'd0, FLT_BUS));
    add_row(sealed(word_of(MODE_COMMAND, 11'd512, 0, 0, 8'h77, 0, 0, 0, 0)), 0, none);
    add_row(word_of(MODE_COMMAND, 11'h7FF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 0, 0, 0),
            0, none);
    add_row(sealed(word_of(MODE_COMMAND, 11'd512, 16'h0FFF, 16'hFFFF, 8'hF8, 0, 0, 0, 0)),
            0, none);
    add_row(word_of(MODE_SAMPLE, 0, 0, 0, 0, 0, 12'hFFF, 12'h001, 0), 0, none);
    add_row(word_of(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1), 0, none);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    end

    for (p = 0; p < PHASES; p++) begin
      new_cmd_id    = 11'($urandom);
      new_status_id = 11'($urandom);
      new_timeout   = 4'($urandom);
      case (p)
        0: begin
          new_cmd_id    = CMD_ID_RESET;
          new_status_id = STATUS_ID_RESET;
          new_timeout   = TIMEOUT_RESET;
        end
        1: begin
          new_cmd_id    = 11'd0;
          new_status_id = 11'h7FF;
          new_timeout   = 4'd0;
        end
        2: begin
          new_cmd_id    = 11'h7FF;
          new_status_id = 11'd0;
          new_timeout   = 4'd15;
        end
        3: new_timeout = 4'd15;
        4: new_timeout = 4'd2;
        default: begin
        end
      endcase
      drain_block();
      apb_write({REG_COMMAND_ID, 2'b00}, {21'd0, new_cmd_id});
      apb_write({REG_STATUS_ID, 2'b00}, {21'd0, new_status_id});
      apb_write({REG_TIMEOUT, 2'b00}, {28'd0, new_timeout});
      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        if (k % 40 == 0) begin
          calm = ($urandom_range(0, 3) == 0);
        end
        if (k == WORDS_PER_PHASE / 2) begin
          drain_block();
        end
        send_word(random_word(), 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
